[hw/rtl/twde_pkg.sv]
// Package for the twin-word difference encoder: result kinds, controller states,
// fixed field widths and the command/status structs between controller and datapath.
// No dependencies.
package twde_pkg;

    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int BYTES_W = 8;
    localparam int COUNT_W = 6;

    localparam logic [WORD_W-1:0] TERM_VALUE = '1;
    localparam logic [BYTES_W-1:0] WORD_BYTES = 8'd4;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAGE   = 3'd0,
        KIND_OFFSET = 3'd1,
        KIND_SIZE   = 3'd2,
        KIND_DATA   = 3'd3,
        KIND_TERM   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAGE,
        S_OFFSET,
        S_SIZE,
        S_DATA,
        S_TERM
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic  load;       // take the input item and update the run state
        logic  data_step;  // move to the next buffered word
        kind_t sel;        // which value to present
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic first_word;  // input item is at position 0 of the page
        logic flush;       // input item closes a run
        logic at_end;      // input item is the last word of the page
        logic data_done;   // current buffered word is the last of the run
    } dp_status_t;

endpackage

[hw/rtl/twin_word_diff_encoder.sv]
// Channel | Direction | Ports                                       | Handshake
// s_      | in        | s_page_number, s_current_word, s_twin_word  | s_valid / s_ready
// m_      | out       | m_kind, m_value, m_last                     | m_valid / m_ready
//
// One item at a time: an item is taken in while idle, then its results are handed
// out in order, each held until m_ready takes it; an item has from 0 to PAGE_WORDS + 3
// results. The controller's emit sequence sets how many.
// aresetn is synchronous, active low; it returns to word position 0 with no run open.
// A stall on m_ready holds the current result; s_ready is high only while idle.
//
// Top level of the twin-word difference encoder. Depends on twde_pkg,
// twde_ctrl, twde_dp and twde_ram.
module twin_word_diff_encoder #(
    parameter int PAGE_WORDS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [twde_pkg::WORD_W-1:0]  s_page_number,
    input  logic [twde_pkg::WORD_W-1:0]  s_current_word,
    input  logic [twde_pkg::WORD_W-1:0]  s_twin_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [twde_pkg::KIND_W-1:0]  m_kind,
    output logic [twde_pkg::WORD_W-1:0]  m_value,
    output logic                         m_last
);

    twde_pkg::dp_cmd_t    cmd;
    twde_pkg::dp_status_t status;

    // Sequence the results of each item: page number, run offset, size,
    // buffered words, terminator, skipping whatever this item does not cause.
    twde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .status  (status)
    );

    // Track the page position and the open run; buffer changed words.
    twde_dp #(
        .PAGE_WORDS (PAGE_WORDS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_page_number  (s_page_number),
        .s_current_word (s_current_word),
        .s_twin_word    (s_twin_word),
        .cmd            (cmd),
        .status         (status),
        .m_value        (m_value)
    );

    // The result kind follows the controller's selection directly.
    assign m_kind = cmd.sel;

`ifndef NO_ASSERTIONS
    // Never take a new item while a result is still on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");

    // The terminator always closes an item's results.
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == twde_pkg::KIND_TERM) |-> m_last)
        else $error("terminator without last");

    // After the last result is taken, the block is idle again.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (!m_valid && s_ready))
        else $error("results continue after last");

    // A size result is always followed by a data word.
    a_size_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_kind == twde_pkg::KIND_SIZE)
            |=> (m_valid && m_kind == twde_pkg::KIND_DATA))
        else $error("run size not followed by data");
`endif

endmodule

[hw/rtl/twde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module twde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/twde_ctrl.sv]
// Controller state machine of the twin-word difference encoder.
// Depends on twde_pkg.
module twde_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_last,
    output twde_pkg::dp_cmd_t      cmd,
    input  twde_pkg::dp_status_t   status
);

    twde_pkg::state_t state_reg, state_next;
    logic flush_reg, flush_next;
    logic term_reg, term_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= twde_pkg::S_IDLE;
            flush_reg <= 1'b0;
            term_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            term_reg  <= term_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        flush_next    = flush_reg;
        term_next     = term_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        m_last        = 1'b0;
        cmd.load      = 1'b0;
        cmd.data_step = 1'b0;
        cmd.sel       = twde_pkg::KIND_PAGE;
        case (state_reg)
            twde_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    flush_next = status.flush;
                    term_next  = status.at_end;
                    if (status.first_word) begin
                        state_next = twde_pkg::S_PAGE;
                    end else if (status.flush) begin
                        state_next = twde_pkg::S_OFFSET;
                    end else if (status.at_end) begin
                        state_next = twde_pkg::S_TERM;
                    end
                end
            end
            twde_pkg::S_PAGE: begin
                m_valid = 1'b1;
                m_last  = !flush_reg && !term_reg;
                cmd.sel = twde_pkg::KIND_PAGE;
                if (m_ready) begin
                    if (flush_reg) begin
                        state_next = twde_pkg::S_OFFSET;
                    end else if (term_reg) begin
                        state_next = twde_pkg::S_TERM;
                    end else begin
                        state_next = twde_pkg::S_IDLE;
                    end
                end
            end
            twde_pkg::S_OFFSET: begin
                m_valid = 1'b1;
                cmd.sel = twde_pkg::KIND_OFFSET;
                if (m_ready) begin
                    state_next = twde_pkg::S_SIZE;
                end
            end
            twde_pkg::S_SIZE: begin
                m_valid = 1'b1;
                cmd.sel = twde_pkg::KIND_SIZE;
                if (m_ready) begin
                    state_next = twde_pkg::S_DATA;
                end
            end
            twde_pkg::S_DATA: begin
                m_valid = 1'b1;
                m_last  = status.data_done && !term_reg;
                cmd.sel = twde_pkg::KIND_DATA;
                if (m_ready) begin
                    if (status.data_done) begin
                        state_next = term_reg ? twde_pkg::S_TERM : twde_pkg::S_IDLE;
                    end else begin
                        cmd.data_step = 1'b1;
                    end
                end
            end
            twde_pkg::S_TERM: begin
                m_valid = 1'b1;
                m_last  = 1'b1;
                cmd.sel = twde_pkg::KIND_TERM;
                if (m_ready) begin
                    state_next = twde_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = twde_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/twde_dp.sv]
// Datapath of the twin-word difference encoder: page position, open-run
// tracking, run word buffer and result value selection.
// Depends on twde_pkg and twde_ram.
module twde_dp #(
    parameter int PAGE_WORDS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [twde_pkg::WORD_W-1:0]   s_page_number,
    input  logic [twde_pkg::WORD_W-1:0]   s_current_word,
    input  logic [twde_pkg::WORD_W-1:0]   s_twin_word,
    input  twde_pkg::dp_cmd_t             cmd,
    output twde_pkg::dp_status_t          status,
    output logic [twde_pkg::WORD_W-1:0]   m_value
);

    localparam int IDX_W = $clog2(PAGE_WORDS);

    logic [twde_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         run_open_reg, run_open_next;
    logic [twde_pkg::POS_W-1:0]   run_start_reg, run_start_next;
    logic [twde_pkg::BYTES_W-1:0] run_bytes_reg, run_bytes_next;
    logic [twde_pkg::WORD_W-1:0]  page_reg;
    logic [twde_pkg::POS_W-1:0]   flush_start_reg;
    logic [twde_pkg::BYTES_W-1:0] flush_bytes_reg;
    logic [twde_pkg::COUNT_W-1:0] idx_reg;

    logic                         diff;
    logic                         at_end;
    logic                         open_eff;
    logic [twde_pkg::POS_W-1:0]   start_eff;
    logic [twde_pkg::BYTES_W-1:0] bytes_eff;
    logic [twde_pkg::COUNT_W-1:0] run_count;
    logic [IDX_W-1:0]             wr_addr;
    logic [twde_pkg::COUNT_W-1:0] rd_idx;
    logic [twde_pkg::WORD_W-1:0]  rd_data;
    logic                         flush;

    assign diff      = s_current_word != s_twin_word;
    assign at_end    = pos_reg == twde_pkg::POS_W'(PAGE_WORDS - 1);
    assign run_count = run_bytes_reg[twde_pkg::BYTES_W-1:2];

    // Fold the present word into the run before deciding whether it closes.
    always_comb begin
        open_eff  = run_open_reg;
        start_eff = run_start_reg;
        bytes_eff = run_bytes_reg;
        wr_addr   = run_count[IDX_W-1:0];
        if (diff) begin
            open_eff = 1'b1;
            if (run_open_reg) begin
                bytes_eff = run_bytes_reg + twde_pkg::WORD_BYTES;
            end else begin
                start_eff = pos_reg;
                bytes_eff = twde_pkg::WORD_BYTES;
                wr_addr   = '0;
            end
        end
    end

    assign flush = (run_open_reg && !diff) || (at_end && open_eff);

    always_comb begin
        pos_next       = pos_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        run_bytes_next = run_bytes_reg;
        if (cmd.load) begin
            pos_next = at_end ? '0 : pos_reg + twde_pkg::POS_W'(1);
            if (flush) begin
                run_open_next  = 1'b0;
                run_start_next = '0;
                run_bytes_next = '0;
            end else begin
                run_open_next  = open_eff;
                run_start_next = start_eff;
                run_bytes_next = bytes_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            run_bytes_reg <= '0;
        end else begin
            pos_reg       <= pos_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            run_bytes_reg <= run_bytes_next;
        end
    end

    // Snapshot of the closing run, held while its results drain.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg        <= s_page_number;
            flush_start_reg <= start_eff;
            flush_bytes_reg <= bytes_eff;
            idx_reg         <= '0;
        end else if (cmd.data_step) begin
            idx_reg <= idx_reg + twde_pkg::COUNT_W'(1);
        end
    end

    // Read one word ahead when stepping so the next word is ready in time.
    assign rd_idx = cmd.data_step ? idx_reg + twde_pkg::COUNT_W'(1) : idx_reg;

    twde_ram #(
        .WIDTH (twde_pkg::WORD_W),
        .DEPTH (PAGE_WORDS)
    ) u_run_ram (
        .aclk    (aclk),
        .wr_en   (cmd.load && diff),
        .wr_addr (wr_addr),
        .wr_data (s_current_word),
        .rd_addr (rd_idx[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign status.first_word = pos_reg == '0;
    assign status.flush      = flush;
    assign status.at_end     = at_end;
    assign status.data_done  = (idx_reg + twde_pkg::COUNT_W'(1))
                               == flush_bytes_reg[twde_pkg::BYTES_W-1:2];

    always_comb begin
        case (cmd.sel)
            twde_pkg::KIND_PAGE:   m_value = page_reg;
            twde_pkg::KIND_OFFSET: m_value = twde_pkg::WORD_W'(flush_start_reg);
            twde_pkg::KIND_SIZE:   m_value = twde_pkg::WORD_W'(flush_bytes_reg);
            twde_pkg::KIND_DATA:   m_value = rd_data;
            twde_pkg::KIND_TERM:   m_value = twde_pkg::TERM_VALUE;
            default:               m_value = twde_pkg::TERM_VALUE;
        endcase
    end

endmodule

[dv/twde_result_checker.sv]
// Result checker for twin_word_diff_encoder: predicts the encoded stream for every item
// taken in and compares it with every result handed out. Depends on twde_pkg.
module twde_result_checker #(
    parameter int PAGE_WORDS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [twde_pkg::WORD_W-1:0]   s_page_number,
    input  logic [twde_pkg::WORD_W-1:0]   s_current_word,
    input  logic [twde_pkg::WORD_W-1:0]   s_twin_word,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [twde_pkg::KIND_W-1:0]   m_kind,
    input  logic [twde_pkg::WORD_W-1:0]   m_value,
    input  logic                          m_last,
    output int                            fail_count,
    output int                            outstanding,
    output int                            results_checked,
    output int                            runs_closed
);

    typedef struct {
        twde_pkg::kind_t             kind;
        logic [twde_pkg::WORD_W-1:0] value;
        logic                        last;
    } diff_result_t;

    diff_result_t expected_results[$];
    diff_result_t item_results[$];
    diff_result_t oldest;

    // predicted encoder state
    logic [twde_pkg::POS_W-1:0]   word_pos;
    logic                         run_active;
    logic [twde_pkg::POS_W-1:0]   run_first;
    logic [twde_pkg::BYTES_W-1:0] run_bytes;
    logic [twde_pkg::WORD_W-1:0]  run_buf [32];

    // emit offset, byte size and buffered words of the open run, then close it
    function automatic void close_run();
        int n;
        n = run_bytes >> 2;
        if (n > 32) n = 32;
        item_results.push_back('{kind: twde_pkg::KIND_OFFSET,
                                 value: {{(twde_pkg::WORD_W-twde_pkg::POS_W){1'b0}}, run_first},
                                 last: 1'b0});
        item_results.push_back('{kind: twde_pkg::KIND_SIZE,
                                 value: {{(twde_pkg::WORD_W-twde_pkg::BYTES_W){1'b0}}, run_bytes},
                                 last: 1'b0});
        for (int k = 0; k < n; k++)
            item_results.push_back('{kind: twde_pkg::KIND_DATA, value: run_buf[k], last: 1'b0});
        run_active = 1'b0;
        run_bytes  = '0;
        run_first  = '0;
        runs_closed++;
    endfunction

    task automatic encode_pair(input logic [twde_pkg::WORD_W-1:0] page, cur, twin);
        item_results.delete();
        if (word_pos == '0)
            item_results.push_back('{kind: twde_pkg::KIND_PAGE, value: page, last: 1'b0});

        if (cur != twin) begin
            if (run_active) begin
                run_buf[run_bytes[6:2]] = cur;
                run_bytes = run_bytes + twde_pkg::WORD_BYTES;
            end else begin
                run_active = 1'b1;
                run_first  = word_pos;
                run_bytes  = twde_pkg::WORD_BYTES;
                run_buf[0] = cur;
            end
        end else if (run_active) begin
            close_run();
        end

        if (int'(word_pos) + 1 >= PAGE_WORDS) begin
            if (run_active) close_run();
            item_results.push_back('{kind: twde_pkg::KIND_TERM, value: twde_pkg::TERM_VALUE,
                                     last: 1'b0});
            word_pos = '0;
        end else begin
            word_pos = word_pos + 1'b1;
        end

        if (item_results.size() > 0)
            item_results[item_results.size()-1].last = 1'b1;
        foreach (item_results[i])
            expected_results.push_back(item_results[i]);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            word_pos   = '0;
            run_active = 1'b0;
            run_first  = '0;
            run_bytes  = '0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                encode_pair(s_page_number, s_current_word, s_twin_word);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"checker: result with nothing pending: ",
                                  "kind %0d value %08h last %0b"},
                                 m_kind, m_value, m_last);
                end else begin
                    oldest = expected_results.pop_front();
                    results_checked++;
                    if (m_kind !== oldest.kind || m_value !== oldest.value
                            || m_last !== oldest.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"checker: mismatch: want %s %08h last %0b, ",
                                      "got kind %0d %08h last %0b"},
                                     oldest.kind.name(), oldest.value, oldest.last,
                                     m_kind, m_value, m_last);
                    end
                end
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

[dv/tb_twin_word_diff_encoder.sv]
// Testbench top for twin_word_diff_encoder: drives pages of word pairs with random
// gaps and receiver stalls, and gives the verdict. Depends on twde_pkg and twde_result_checker.
module tb_twin_word_diff_encoder;

    localparam int PAGE_WORDS     = 32;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 196;
    localparam int LONG_HOLD      = 300;
    localparam int IDLE_LIMIT     = 2000;

    // how the changed words are spread over a page
    typedef enum {
        PAGE_QUIET,
        PAGE_ALL_CHANGED,
        PAGE_SPARSE,
        PAGE_DENSE,
        PAGE_ALTERNATE
    } page_mode_t;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic [twde_pkg::WORD_W-1:0]         s_page_number  = '0;
    logic [twde_pkg::WORD_W-1:0]         s_current_word = '0;
    logic [twde_pkg::WORD_W-1:0]         s_twin_word    = '0;
    logic                                m_ready        = 1'b0;
    logic                                s_ready;
    logic                                m_valid;
    logic [twde_pkg::KIND_W-1:0]         m_kind;
    logic [twde_pkg::WORD_W-1:0]         m_value;
    logic                                m_last;

    int checker_fails;
    int outstanding;
    int results_checked;
    int runs_closed;

    int items_sent;
    int holds_done;
    int drain_pauses;
    int stall_left;
    int rx_cycle;
    int rx_roll;
    int idle_cycles;

    always #5 aclk = ~aclk;

    twin_word_diff_encoder #(
        .PAGE_WORDS(PAGE_WORDS)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page_number (s_page_number),
        .s_current_word(s_current_word),
        .s_twin_word   (s_twin_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_value       (m_value),
        .m_last        (m_last)
    );

    twde_result_checker #(
        .PAGE_WORDS(PAGE_WORDS)
    ) result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .s_current_word (s_current_word),
        .s_twin_word    (s_twin_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_value        (m_value),
        .m_last         (m_last),
        .fail_count     (checker_fails),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .runs_closed    (runs_closed)
    );

    // Receiver. Mostly short random stalls with the odd long one, a calm stretch
    // of always-ready at the start of each rx_cycle period, and two long hold-offs once enough items
    // have gone in, so the encoder keeps its results pending and holds s_ready low.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if ((items_sent >= 60 && holds_done == 0)
                || (items_sent >= 170 && holds_done == 1)) begin
            m_ready    <= 1'b0;
            stall_left <= LONG_HOLD;
            holds_done <= holds_done + 1;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_cycle % 512 < 128) begin
            m_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_ready <= 1'b1;
            end else if (rx_roll < 95) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(10, 40);
            end
        end
        rx_cycle <= rx_cycle + 1;
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: no item moved for %0d cycles", IDLE_LIMIT);
            $display("tb_twin_word_diff_encoder: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one; none on calm pages.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one item and hold it until it is taken. valid stays high straight
    // into the next item when there is no gap.
    task automatic offer_item(input logic [twde_pkg::WORD_W-1:0] page, cur, twin,
                              input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_page_number  <= page;
        s_current_word <= cur;
        s_twin_word    <= twin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent <= items_sent + 1;
    endtask

    // Wait for a clock edge first so the checker has seen the last item, then
    // hold until every predicted result has come out.
    task automatic wait_drained();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic [twde_pkg::WORD_W-1:0] pg;
        logic [twde_pkg::WORD_W-1:0] cw;
        logic [twde_pkg::WORD_W-1:0] tw;
        logic [twde_pkg::WORD_W-1:0] mask;
        bit                          differ;
        bit                          calm;
        int                          pos_in_page;
        int                          pages_started;
        page_mode_t                  mode;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening of page one: extreme words and page number, a two-word
        // run closed by an equal word, an item that causes nothing, single-bit and
        // single-word runs, and a page number that must be ignored off position 0.
        for (int i = 0; i < DIRECTED_ITEMS; i++) begin
            case (i)
                0: begin
                    pg = '1;  cw = '1;  tw = '0;
                end
                1: begin
                    pg = '0;  cw = '0;  tw = '1;
                end
                2: begin
                    pg = 32'h1234_5678;  cw = '0;  tw = '0;
                end
                3: begin
                    pg = '1;  cw = '1;  tw = '1;
                end
                4: begin
                    pg = $urandom;  cw = 32'h8000_0000;  tw = '0;
                end
                5: begin
                    pg = $urandom;  cw = 32'h0000_0001;  tw = 32'h0000_0001;
                end
                6: begin
                    pg = $urandom;  cw = 32'h0000_0001;  tw = '0;
                end
                7: begin
                    pg = $urandom;  cw = 32'hA5A5_A5A5;  tw = 32'h5A5A_5A5A;
                end
                default: begin
                    pg = $urandom;
                    cw = $urandom;
                    tw = (i inside {[12:14], 17, [20:23]}) ? ~cw : cw;
                end
            endcase
            offer_item(pg, cw, tw, pick_gap(1'b0));
        end
        pos_in_page   = DIRECTED_ITEMS;
        pages_started = 1;
        calm          = 1'b0;
        // keep changing to the end so the open run is flushed on the last word
        mode          = PAGE_ALL_CHANGED;

        for (int n = 0; n < RANDOM_ITEMS || pos_in_page != 0; n++) begin
            if (pos_in_page == 0) begin
                pages_started++;
                // the second page changes every word: the longest burst of results
                mode = (pages_started == 2) ? PAGE_ALL_CHANGED
                                            : page_mode_t'($urandom_range(0, 4));
                calm = ($urandom_range(0, 3) == 0);
                // on some page boundaries let the output run dry before going on
                if (pages_started == 2 || $urandom_range(0, 3) == 0) begin
                    s_valid <= 1'b0;
                    wait_drained();
                    drain_pauses++;
                end
            end

            case (mode)
                PAGE_QUIET:       differ = 1'b0;
                PAGE_ALL_CHANGED: differ = 1'b1;
                PAGE_SPARSE:      differ = ($urandom_range(0, 9) == 0);
                PAGE_DENSE:       differ = ($urandom_range(0, 9) < 7);
                default:          differ = (pos_in_page % 2 == 1);
            endcase

            case ($urandom_range(0, 15))
                0:       cw = '0;
                1:       cw = '1;
                default: cw = $urandom;
            endcase
            // flip a single bit now and then, otherwise a random pattern
            mask = ($urandom_range(0, 3) == 0) ? (32'h1 << $urandom_range(0, 31))
                                               : $urandom;
            if (mask == '0) mask = 32'h8000_0000;
            tw = differ ? (cw ^ mask) : cw;

            offer_item($urandom, cw, tw, pick_gap(calm));
            pos_in_page = (pos_in_page + 1) % PAGE_WORDS;
        end
        s_valid <= 1'b0;

        wait_drained();
        repeat (PAGE_WORDS + 8) @(posedge aclk);

        $display("tb: %0d items over %0d pages, %0d results checked, %0d runs closed",
                 items_sent, pages_started, results_checked, runs_closed);
        $display("tb: %0d long receiver hold-offs, %0d sender pauses to empty",
                 holds_done, drain_pauses);
        if (checker_fails == 0 && outstanding == 0) begin
            $display("tb_twin_word_diff_encoder: done, clean");
        end else begin
            $display("tb: %0d failures, %0d results never arrived", checker_fails, outstanding);
            $display("tb_twin_word_diff_encoder: done, errors");
        end
        $finish;
    end

endmodule
